@@ design/vndr_pkg.sv @@
// ----------------------------------------------------------------------------
// vndr_pkg
// Shared widths, operation codes, hash constants and default sizes for the
// vertex deduplication and index remap block.
// ----------------------------------------------------------------------------
package vndr_pkg;

    // field widths of the corner and result words
    localparam int OP_W  = 2;
    localparam int VTX_W = 12;
    localparam int NRM_W = 12;
    localparam int IDX_W = 12;

    // operation codes
    localparam logic [OP_W-1:0] OP_WITH_NORMAL    = 2'd0;
    localparam logic [OP_W-1:0] OP_WITHOUT_NORMAL = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR          = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED         = 2'd3;

    // default sizes
    localparam int SOURCE_VERTS_DEF = 4096;
    localparam int OUT_VERTS_DEF    = 4096;
    localparam int PAIR_SLOTS_DEF   = 8192;

    // pair hash multipliers
    localparam logic [31:0] HASH_MUL_V = 32'd2654435761;
    localparam logic [15:0] HASH_MUL_N = 16'd40503;

    // 32-bit pair hash before reduction to a slot number
    function automatic logic [31:0] pair_hash(input logic [VTX_W-1:0] v,
                                              input logic [NRM_W-1:0] n);
        logic [31:0] hv;
        logic [31:0] hn;
        hv = 32'({20'd0, v} * HASH_MUL_V);
        hn = 32'({20'd0, n} * {16'd0, HASH_MUL_N});
        return hv ^ hn ^ ({20'd0, n} << 7);
    endfunction

endpackage

@@ design/vndr_corner_if.sv @@
// ----------------------------------------------------------------------------
// vndr_corner_if
// Corner channel: operation code plus source vertex and normal indices.
// ----------------------------------------------------------------------------
interface vndr_corner_if;
    logic                        valid;
    logic                        ready;
    logic [vndr_pkg::OP_W-1:0]   operation;
    logic [vndr_pkg::VTX_W-1:0]  source_vertex;
    logic [vndr_pkg::NRM_W-1:0]  source_normal;

    modport source (output valid, output operation, output source_vertex,
                    output source_normal, input ready);
    modport sink   (input valid, input operation, input source_vertex,
                    input source_normal, output ready);
endinterface

@@ design/vndr_result_if.sv @@
// ----------------------------------------------------------------------------
// vndr_result_if
// Result channel: compact index, creation flags and fetch indices.
// ----------------------------------------------------------------------------
interface vndr_result_if;
    logic                        valid;
    logic                        ready;
    logic [vndr_pkg::IDX_W-1:0]  compact_index;
    logic                        is_new;
    logic                        dummy_normal;
    logic [vndr_pkg::VTX_W-1:0]  fetch_vertex;
    logic [vndr_pkg::NRM_W-1:0]  fetch_normal;
    logic                        overflow;

    modport source (output valid, output compact_index, output is_new,
                    output dummy_normal, output fetch_vertex, output fetch_normal,
                    output overflow, input ready);
    modport sink   (input valid, input compact_index, input is_new,
                    input dummy_normal, input fetch_vertex, input fetch_normal,
                    input overflow, output ready);
endinterface

@@ design/vertex_normal_dedup_remap.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_dedup_remap
// Maps (vertex, normal) corners and bare vertex corners of a multi-index mesh
// to compact single indices, using a linear-probed pair table and a vertex map
// held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+------------------------------------------------------------
//  corner   | in  | operation, source_vertex, source_normal
//  result   | out | compact_index, is_new, dummy_normal, fetch_vertex,
//           |     | fetch_normal, overflow
//
//  One corner at a time. Bare vertex corner: states IDLE, VCHK, OUT. Corner with
//  normal: IDLE, HASH, then PRD and PCMP for each pair-table probe, then OUT;
//  the MOD reduction steps follow HASH when PAIR_SLOTS is not a power of two.
//  After reset and on each clear the RAMs are swept, one entry per cycle, over
//  max(SOURCE_VERTS, PAIR_SLOTS) entries; no corner is taken meanwhile.
//  A new corner is taken while the previous result still waits in the output
//  register; a result stalled by the sink holds the next one back.
// ----------------------------------------------------------------------------
module vertex_normal_dedup_remap #(
    parameter int SOURCE_VERTS = vndr_pkg::SOURCE_VERTS_DEF,
    parameter int OUT_VERTS    = vndr_pkg::OUT_VERTS_DEF,
    parameter int PAIR_SLOTS   = vndr_pkg::PAIR_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    vndr_corner_if.sink       corner,
    vndr_result_if.source     result
);

    localparam int VAW   = $clog2(SOURCE_VERTS);
    localparam int PAW   = $clog2(PAIR_SLOTS);
    localparam int CIW   = $clog2(OUT_VERTS);
    localparam int NIW   = $clog2(OUT_VERTS + 1);
    localparam int PCW   = $clog2(PAIR_SLOTS + 1);
    localparam int MAXD  = (SOURCE_VERTS > PAIR_SLOTS) ? SOURCE_VERTS : PAIR_SLOTS;
    localparam int SWW   = $clog2(MAXD);
    localparam bit POW2  = ((PAIR_SLOTS & (PAIR_SLOTS - 1)) == 0);
    localparam int VMW   = 1 + CIW;
    localparam int PTW   = 1 + vndr_pkg::VTX_W + vndr_pkg::NRM_W + CIW;
    localparam int RSH   = 31 + PAW;
    localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / PAIR_SLOTS);

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PCMP  = 4'd5;
    localparam logic [3:0] S_VCHK  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    typedef struct packed {
        logic [vndr_pkg::IDX_W-1:0] compact_index;
        logic                       is_new;
        logic                       dummy_normal;
        logic [vndr_pkg::VTX_W-1:0] fetch_vertex;
        logic [vndr_pkg::NRM_W-1:0] fetch_normal;
        logic                       overflow;
    } res_t;

    logic [3:0]                  state_reg, state_next;
    logic [SWW-1:0]              sweep_reg, sweep_next;
    logic                        clr_pend_reg, clr_pend_next;
    logic [NIW-1:0]              next_idx_reg, next_idx_next;
    logic                        seen_reg, seen_next;
    logic [vndr_pkg::VTX_W-1:0]  v_reg, v_next;
    logic [vndr_pkg::NRM_W-1:0]  n_reg, n_next;
    logic [31:0]                 h_reg, h_next;
    logic [31:0]                 q_reg, q_next;
    logic [PAW:0]                rem_reg, rem_next;
    logic [1:0]                  step_reg, step_next;
    logic [PAW-1:0]              pos_reg, pos_next;
    logic [PCW-1:0]              probe_reg, probe_next;
    res_t                        res_reg, res_next;
    res_t                        out_reg, out_next;
    logic                        out_vld_reg, out_vld_next;

    logic                        vm_we;
    logic [VAW-1:0]              vm_waddr, vm_raddr;
    logic [VMW-1:0]              vm_wdata, vm_rdata;
    logic                        pt_we;
    logic [PAW-1:0]              pt_waddr;
    logic [PTW-1:0]              pt_wdata, pt_rdata;

    logic                        sweeping;
    logic [CIW-1:0]              new_idx;
    logic                        idx_full;
    logic [31:0]                 h_comb;
    logic [63:0]                 q_prod;
    logic [31:0]                 r_full;
    logic                        pt_valid;
    logic [vndr_pkg::VTX_W-1:0]  pt_vert;
    logic [vndr_pkg::NRM_W-1:0]  pt_norm;
    logic [CIW-1:0]              pt_idx;
    logic                        vm_valid;
    logic [CIW-1:0]              vm_idx;
    res_t                        res_zero;

    // state memories
    vndr_ram #(.WIDTH(VMW), .DEPTH(SOURCE_VERTS)) u_vmap (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    vndr_ram #(.WIDTH(PTW), .DEPTH(PAIR_SLOTS)) u_pairs (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pos_reg),
        .rdata (pt_rdata)
    );

    // decoded memory words and common terms
    assign {pt_valid, pt_vert, pt_norm, pt_idx} = pt_rdata;
    assign {vm_valid, vm_idx}                    = vm_rdata;
    assign sweeping  = (state_reg == S_SWEEP);
    assign new_idx   = CIW'(next_idx_reg);
    assign idx_full  = (32'(next_idx_reg) >= 32'(OUT_VERTS));
    assign h_comb    = vndr_pkg::pair_hash(v_reg, n_reg);
    assign q_prod    = {32'd0, h_reg} * {32'd0, RECIP};
    assign r_full    = h_reg - q_reg * 32'(PAIR_SLOTS);
    assign res_zero  = '0;
    assign vm_raddr  = (state_reg == S_IDLE) ? VAW'(corner.source_vertex) : VAW'(v_reg);

    // handshake and output word
    assign corner.ready         = (state_reg == S_IDLE);
    assign result.valid         = out_vld_reg;
    assign result.compact_index = out_reg.compact_index;
    assign result.is_new        = out_reg.is_new;
    assign result.dummy_normal  = out_reg.dummy_normal;
    assign result.fetch_vertex  = out_reg.fetch_vertex;
    assign result.fetch_normal  = out_reg.fetch_normal;
    assign result.overflow      = out_reg.overflow;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        clr_pend_next = clr_pend_reg;
        next_idx_next = next_idx_reg;
        seen_next     = seen_reg;
        v_next        = v_reg;
        n_next        = n_reg;
        h_next        = h_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        probe_next    = probe_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        vm_we         = 1'b0;
        vm_waddr      = VAW'(v_reg);
        vm_wdata      = {1'b1, new_idx};
        pt_we         = 1'b0;
        pt_waddr      = pos_reg;
        pt_wdata      = {1'b1, v_reg, n_reg, new_idx};

        if (out_vld_reg && result.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                vm_we    = (32'(sweep_reg) < 32'(SOURCE_VERTS));
                vm_waddr = VAW'(sweep_reg);
                vm_wdata = '0;
                pt_we    = (32'(sweep_reg) < 32'(PAIR_SLOTS));
                pt_waddr = PAW'(sweep_reg);
                pt_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (32'(sweep_reg) == 32'(MAXD - 1))
                begin
                    sweep_next    = '0;
                    clr_pend_next = 1'b0;
                    res_next      = res_zero;
                    state_next    = clr_pend_reg ? S_OUT : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (corner.valid)
                begin
                    v_next   = corner.source_vertex;
                    n_next   = corner.source_normal;
                    res_next = res_zero;
                    if (corner.operation == vndr_pkg::OP_CLEAR)
                    begin
                        next_idx_next = '0;
                        seen_next     = 1'b0;
                        clr_pend_next = 1'b1;
                        sweep_next    = '0;
                        state_next    = S_SWEEP;
                    end
                    else if (corner.operation == vndr_pkg::OP_UNUSED)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (corner.operation == vndr_pkg::OP_WITH_NORMAL)
                        begin
                            seen_next = 1'b1;
                        end
                        if (32'(corner.source_vertex) >= 32'(SOURCE_VERTS))
                        begin
                            res_next.overflow = 1'b1;
                            state_next        = S_OUT;
                        end
                        else if (corner.operation == vndr_pkg::OP_WITH_NORMAL)
                        begin
                            state_next = S_HASH;
                        end
                        else
                        begin
                            state_next = S_VCHK;
                        end
                    end
                end
            end

            // hash the pair, reduce to a slot number
            S_HASH:
            begin
                probe_next = '0;
                if (POW2)
                begin
                    pos_next   = PAW'(h_comb);
                    state_next = S_PRD;
                end
                else
                begin
                    h_next     = h_comb;
                    step_next  = '0;
                    state_next = S_MOD;
                end
            end

            // remainder by reciprocal multiply, then one correcting subtract
            S_MOD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd0)
                begin
                    q_next = 32'(q_prod >> RSH);
                end
                else if (step_reg == 2'd1)
                begin
                    rem_next = r_full[PAW:0];
                end
                else
                begin
                    pos_next   = (32'(rem_reg) >= 32'(PAIR_SLOTS))
                               ? PAW'(rem_reg - (PAW+1)'(PAIR_SLOTS)) : PAW'(rem_reg);
                    state_next = S_PRD;
                end
            end

            // slot read in flight
            S_PRD:
            begin
                state_next = S_PCMP;
            end

            // examine one probed slot
            S_PCMP:
            begin
                state_next = S_OUT;
                if (!pt_valid)
                begin
                    if (idx_full)
                    begin
                        res_next.overflow = 1'b1;
                    end
                    else
                    begin
                        pt_we         = 1'b1;
                        vm_we         = !vm_valid;
                        next_idx_next = next_idx_reg + 1'b1;
                        res_next.compact_index = vndr_pkg::IDX_W'(new_idx);
                        res_next.is_new        = 1'b1;
                        res_next.fetch_vertex  = v_reg;
                        res_next.fetch_normal  = n_reg;
                    end
                end
                else if (pt_vert == v_reg && pt_norm == n_reg)
                begin
                    res_next.compact_index = vndr_pkg::IDX_W'(pt_idx);
                end
                else if (32'(probe_reg) == 32'(PAIR_SLOTS - 1))
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    pos_next   = (32'(pos_reg) == 32'(PAIR_SLOTS - 1))
                               ? '0 : pos_reg + 1'b1;
                    state_next = S_PRD;
                end
            end

            // bare vertex lookup
            S_VCHK:
            begin
                state_next = S_OUT;
                if (vm_valid)
                begin
                    res_next.compact_index = vndr_pkg::IDX_W'(vm_idx);
                end
                else if (idx_full)
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    vm_we         = 1'b1;
                    next_idx_next = next_idx_reg + 1'b1;
                    res_next.compact_index = vndr_pkg::IDX_W'(new_idx);
                    res_next.is_new        = 1'b1;
                    res_next.dummy_normal  = seen_reg;
                    res_next.fetch_vertex  = v_reg;
                end
            end

            // hand the word to the output register once it is free
            S_OUT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            sweep_reg    <= '0;
            clr_pend_reg <= 1'b0;
            next_idx_reg <= '0;
            seen_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            clr_pend_reg <= clr_pend_next;
            next_idx_reg <= next_idx_next;
            seen_reg     <= seen_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        n_reg     <= n_next;
        h_reg     <= h_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        pos_reg   <= pos_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

@@ design/vndr_ram.sv @@
// ----------------------------------------------------------------------------
// vndr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vndr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
